### rtl/assert_macros.svh
// Assertion macros of the telnet input line editor, used by its datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("line editor assertion failed");

// Next-cycle implication, disabled during reset.
`define LIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("line editor assertion failed");

`endif

### rtl/lie_pkg.sv
// Types, codes and constants of the telnet input line editor.
package lie_pkg;

    localparam int LINE_BYTES_DEF = 32;

    localparam logic [7:0] TEL_IAC    = 8'hFF;
    localparam logic [7:0] TEL_WILL   = 8'hFB;
    localparam logic [7:0] TEL_DONT   = 8'hFE;
    localparam logic [7:0] TEL_SB     = 8'hFA;
    localparam logic [7:0] TEL_SE     = 8'hF0;
    localparam logic [7:0] KEY_NUL    = 8'h00;
    localparam logic [7:0] KEY_CTRL_C = 8'h03;
    localparam logic [7:0] KEY_CTRL_D = 8'h04;
    localparam logic [7:0] KEY_BS     = 8'h08;
    localparam logic [7:0] KEY_LF     = 8'h0A;
    localparam logic [7:0] KEY_CR     = 8'h0D;
    localparam logic [7:0] KEY_SPACE  = 8'h20;
    localparam logic [7:0] KEY_C      = 8'h43;
    localparam logic [7:0] KEY_CARET  = 8'h5E;
    localparam logic [7:0] KEY_DEL    = 8'h7F;

    localparam logic DEST_CLIENT  = 1'b0;
    localparam logic DEST_COMMAND = 1'b1;

    typedef enum logic [2:0] {
        MODE_DATA,
        MODE_CMD,
        MODE_OPTION,
        MODE_SUBNEG,
        MODE_SUBNEG_CMD
    } t_lie_mode;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_ECHO,
        KIND_ERASE,
        KIND_INTR,
        KIND_EOF,
        KIND_SUBMIT
    } t_lie_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT
    } t_lie_state;

    typedef struct packed {
        logic load;
        logic commit;
        logic emit;
    } t_lie_cmd;

    typedef struct packed {
        logic has_results;
        logic can_emit;
        logic at_last;
    } t_lie_sts;

endpackage

### rtl/telnet_input_line_editor.sv
// Top level of the telnet input line editor: controller and datapath.
//
// Input stream: one raw byte from the telnet client per transaction on
// s_axis. Telnet commands (IAC verb option, IAC cmd, IAC SB ... IAC SE)
// are stripped; the rest drives a line editor with a LINE_BYTES store.
// Output stream: one result byte per transaction on m_axis; tuser[0] picks
// the destination (0 echo to client, 1 command input), tuser[1] flags the
// Ctrl-D end-of-file result, tlast marks the final result of an input byte.
// Timing: a byte is taken, decoded in the next cycle, and its n results
// leave the output register one per cycle while the receiver does not stall.
// A line submit gives up to LINE_BYTES + 2 results. A byte with no result
// goes back to the accept state after decode and puts nothing out.
// Reset (i_rst_n low, synchronous) returns the parser to data mode, empties
// the line and drops any pending result.
// A stalled receiver holds the output register; emission pauses and no new
// byte is taken until the current byte's results are all in the register.
module telnet_input_line_editor
    import lie_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] data_byte
    output logic       m_axis_tlast,
    output logic [1:0] m_axis_tuser    // [0] destination, [1] session_end
);

    t_lie_cmd cmd;
    t_lie_sts sts;

    lie_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_sts     (sts),
        .o_s_tready(s_axis_tready),
        .o_cmd     (cmd)
    );

    lie_datapath #(
        .LINE_BYTES(LINE_BYTES)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tdata (s_axis_tdata),
        .i_m_tready(m_axis_tready),
        .i_cmd     (cmd),
        .o_sts     (sts),
        .o_m_tvalid(m_axis_tvalid),
        .o_m_tdata (m_axis_tdata),
        .o_m_tlast (m_axis_tlast),
        .o_m_tuser (m_axis_tuser)
    );

endmodule

### rtl/lie_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lie_ram
    import lie_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = LINE_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/lie_datapath.sv
// Datapath: telnet parser state, line store, result sequencing and output register.
`include "assert_macros.svh"
module lie_datapath
    import lie_pkg::*;
#(
    parameter int LINE_BYTES = LINE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_s_tdata,
    input  logic       i_m_tready,
    input  t_lie_cmd   i_cmd,
    output t_lie_sts   o_sts,
    output logic       o_m_tvalid,
    output logic [7:0] o_m_tdata,
    output logic       o_m_tlast,
    output logic [1:0] o_m_tuser
);

    localparam int LW = $clog2(LINE_BYTES);
    localparam int CW = $clog2(LINE_BYTES + 3);

    logic [7:0]    r_byte;
    t_lie_mode     r_mode;
    logic          r_swallow;
    logic [LW-1:0] r_len;
    t_lie_kind     r_kind;
    logic [CW-1:0] r_seq_len;
    logic [CW-1:0] r_cnt;
    logic          r_out_valid;
    logic [7:0]    r_out_data;
    logic          r_out_dest;
    logic          r_out_end;
    logic          r_out_last;

    t_lie_mode     n_mode;
    logic          n_swallow;
    logic [LW-1:0] n_len;
    t_lie_kind     d_kind;
    logic [CW-1:0] d_seq_len;
    logic          to_editor;
    logic          skip;

    logic [7:0]    e_data;
    logic          e_dest;
    logic          e_end;
    logic          at_last;
    logic          can_emit;
    logic [CW-1:0] rd_idx;
    logic [7:0]    ram_rdata;

    always_comb begin
        n_mode    = r_mode;
        to_editor = 1'b0;
        unique case (r_mode)
            MODE_CMD: begin
                if (r_byte == TEL_IAC) begin
                    to_editor = 1'b1;
                    n_mode    = MODE_DATA;
                end else if (r_byte >= TEL_WILL && r_byte <= TEL_DONT) begin
                    n_mode = MODE_OPTION;
                end else if (r_byte == TEL_SB) begin
                    n_mode = MODE_SUBNEG;
                end else begin
                    n_mode = MODE_DATA;
                end
            end
            MODE_OPTION: begin
                n_mode = MODE_DATA;
            end
            MODE_SUBNEG: begin
                if (r_byte == TEL_IAC) begin
                    n_mode = MODE_SUBNEG_CMD;
                end
            end
            MODE_SUBNEG_CMD: begin
                n_mode = (r_byte == TEL_SE) ? MODE_DATA : MODE_SUBNEG;
            end
            default: begin
                if (r_byte == TEL_IAC) begin
                    n_mode = MODE_CMD;
                end else begin
                    n_mode    = MODE_DATA;
                    to_editor = 1'b1;
                end
            end
        endcase

        d_kind    = KIND_NONE;
        n_swallow = r_swallow;
        n_len     = r_len;
        skip      = 1'b0;
        if (to_editor) begin
            if (r_swallow) begin
                n_swallow = 1'b0;
                skip      = (r_byte == KEY_LF) || (r_byte == KEY_NUL);
            end
            if (!skip) begin
                priority if (r_byte == KEY_CR) begin
                    n_swallow = 1'b1;
                    d_kind    = KIND_SUBMIT;
                    n_len     = '0;
                end else if (r_byte == KEY_LF) begin
                    d_kind = KIND_SUBMIT;
                    n_len  = '0;
                end else if (r_byte == KEY_BS || r_byte == KEY_DEL) begin
                    if (r_len != '0) begin
                        d_kind = KIND_ERASE;
                        n_len  = r_len - LW'(1);
                    end
                end else if (r_byte == KEY_CTRL_C) begin
                    d_kind = KIND_INTR;
                    n_len  = '0;
                end else if (r_byte == KEY_CTRL_D) begin
                    if (r_len == '0) begin
                        d_kind = KIND_EOF;
                    end
                end else if (r_byte >= KEY_SPACE && r_byte < KEY_DEL &&
                             r_len < LW'(LINE_BYTES - 1)) begin
                    d_kind = KIND_ECHO;
                    n_len  = r_len + LW'(1);
                end else begin
                    d_kind = KIND_NONE;
                end
            end
        end

        unique case (d_kind)
            KIND_ERASE:  d_seq_len = CW'(3);
            KIND_INTR:   d_seq_len = CW'(5);
            KIND_SUBMIT: d_seq_len = CW'(r_len) + CW'(3);
            default:     d_seq_len = CW'(1);
        endcase
    end

    always_comb begin
        e_data = r_byte;
        e_dest = DEST_CLIENT;
        e_end  = 1'b0;
        unique case (r_kind)
            KIND_ERASE: begin
                e_data = (r_cnt == CW'(1)) ? KEY_SPACE : KEY_BS;
            end
            KIND_INTR: begin
                priority if (r_cnt == CW'(0)) begin
                    e_data = KEY_CARET;
                end else if (r_cnt == CW'(1)) begin
                    e_data = KEY_C;
                end else if (r_cnt == CW'(2)) begin
                    e_data = KEY_CR;
                end else if (r_cnt == CW'(3)) begin
                    e_data = KEY_LF;
                end else begin
                    e_data = KEY_CTRL_C;
                    e_dest = DEST_COMMAND;
                end
            end
            KIND_EOF: begin
                e_data = KEY_CTRL_D;
                e_dest = DEST_COMMAND;
                e_end  = 1'b1;
            end
            KIND_SUBMIT: begin
                priority if (r_cnt == CW'(0)) begin
                    e_data = KEY_CR;
                end else if (r_cnt == CW'(1)) begin
                    e_data = KEY_LF;
                end else if (at_last) begin
                    e_data = KEY_LF;
                    e_dest = DEST_COMMAND;
                end else begin
                    e_data = ram_rdata;
                    e_dest = DEST_COMMAND;
                end
            end
            default: begin
                e_data = r_byte;
            end
        endcase
    end

    assign at_last  = (r_cnt == r_seq_len - CW'(1));
    assign can_emit = !r_out_valid || i_m_tready;
    assign rd_idx   = r_cnt - CW'(1);

    lie_ram #(
        .WIDTH(8),
        .DEPTH(LINE_BYTES)
    ) u_line_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.commit && d_kind == KIND_ECHO),
        .i_waddr(r_len),
        .i_wdata(r_byte),
        .i_re   (i_cmd.emit),
        .i_raddr(rd_idx[LW-1:0]),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_DATA;
            r_swallow   <= 1'b0;
            r_len       <= '0;
            r_kind      <= KIND_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_mode    <= n_mode;
                r_swallow <= n_swallow;
                r_len     <= n_len;
                r_kind    <= d_kind;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte <= i_s_tdata;
        end
        if (i_cmd.commit) begin
            r_seq_len <= d_seq_len;
            r_cnt     <= '0;
        end else if (i_cmd.emit) begin
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.emit) begin
            r_out_data <= e_data;
            r_out_dest <= e_dest;
            r_out_end  <= e_end;
            r_out_last <= at_last;
        end
    end

    assign o_sts.has_results = (d_kind != KIND_NONE);
    assign o_sts.can_emit    = can_emit;
    assign o_sts.at_last     = at_last;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_end, r_out_dest};

    `LIE_ASSERT_IMP(a_emit_has_room, i_clk, i_rst_n, i_cmd.emit, can_emit)
    `LIE_ASSERT_NXT(a_submit_clears, i_clk, i_rst_n,
                    i_cmd.commit && d_kind == KIND_SUBMIT, r_len == '0)
    `LIE_ASSERT_NXT(a_last_marked, i_clk, i_rst_n,
                    i_cmd.emit && at_last, r_out_valid && r_out_last)

endmodule

### rtl/lie_ctrl.sv
// Controller: sequences accept, decode and result emission for each input byte.
module lie_ctrl
    import lie_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_s_tvalid,
    input  t_lie_sts i_sts,
    output logic     o_s_tready,
    output t_lie_cmd o_cmd
);

    t_lie_state r_state;
    t_lie_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.commit = 1'b1;
                n_state      = i_sts.has_results ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.at_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
